// ----- hdl/fcts_pkg.sv -----
// Shared constants, types and helpers of the floor and ceiling texel shader.
package fcts_pkg;

  localparam int TexSideLog2 = 6;
  localparam int TexSide     = 1 << TexSideLog2;
  localparam int StoreAw     = 12;
  localparam int StoreDepth  = 1 << StoreAw;
  localparam int DistBits    = 32;
  localparam int ShadeBits   = 17;

  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindFloor = 2'd1;
  localparam logic [1:0] KindCeil  = 2'd2;
  localparam logic [1:0] KindNone  = 2'd3;

  localparam logic [1:0] RegEye     = 2'd0;
  localparam logic [1:0] RegHorizon = 2'd1;
  localparam logic [1:0] RegFade    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
    logic [11:0] idx;
    logic [23:0] color;
  } item_t;

  typedef struct packed {
    logic [31:0] base_u;
    logic [31:0] base_v;
    logic [31:0] step_u;
    logic [31:0] step_v;
  } geom_t;

  typedef struct packed {
    logic        last;
    logic [23:0] color;
    logic [11:0] row;
    logic [11:0] column;
  } out_t;

  // Q32.32 product to Q32.16, rounded toward zero.
  function automatic logic [47:0] trunc16(input logic [63:0] p);
    logic [63:0] s;
    s = p + (p[63] ? 64'h0000_0000_0000_FFFF : 64'd0);
    return s[63:16];
  endfunction

  // Clamp a 49-bit signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [48:0] s);
    logic ovf;
    ovf = (s[48:31] != {18{s[48]}});
    if (ovf) return s[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  // Whole part of a Q16.16 coordinate, wrapped to the texture side.
  function automatic logic [TexSideLog2-1:0] coord_wrap(input logic [31:0] q);
    logic [32:0] s;
    s = {q[31], q} + (q[31] ? 33'h0_0000_FFFF : 33'd0);
    return s[16 +: TexSideLog2];
  endfunction

endpackage

// ----- hdl/floor_ceiling_texel_shader.sv -----
// Pipelined floor and ceiling texel shader with texture store and APB registers.
//
//  channel | port group                    | payload
//  --------+-------------------------------+----------------------------------------
//  in      | s_tvalid s_tready s_tdata     | tuser kind, tlast last_row, tdata below
//  out     | m_tvalid m_tready m_tdata     | tlast out_last, tdata below
//  config  | psel penable pwrite paddr ... | eye_height 0x0, horizon_row 0x4, fade 0x8
//
// One request enters per cycle while the output queue has room. The depth is set mostly
// by the two restoring dividers, one quotient bit per stage: 32 stages for the distance
// and 17 for the shade. Loads write the texture store at the same stage pixels read it, so
// every request sees exactly the loads that came before. A two-entry output queue holds
// results; the whole pipe halts only when it is full.
// Reset is synchronous and clears valid bits, the queue and the registers.
module floor_ceiling_texel_shader (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // column[11:0] row[23:12] base_u[55:24] base_v[87:56] step_u[119:88]
  // step_v[151:120] texel_index[163:152] texel_color[187:164], zero pad
  input  logic [191:0] s_tdata,
  input  logic [1:0]   s_tuser,  // kind
  input  logic         s_tlast,  // last_row
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_column[11:0] out_row[23:12] pixel_color[47:24]
  output logic [47:0]  m_tdata,
  output logic         m_tlast   // out_last
);

  localparam int Nd = fcts_pkg::DistBits;
  localparam int Ns = fcts_pkg::ShadeBits;

  // Configuration registers
  logic [31:0] eye_height;
  logic [10:0] horizon_row;
  logic [31:0] fade_distance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_height    <= 32'h0000_8000;
      horizon_row   <= 11'd240;
      fade_distance <= 32'h0001_0000;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        fcts_pkg::RegEye:     eye_height    <= pwdata;
        fcts_pkg::RegHorizon: horizon_row   <= pwdata[10:0];
        fcts_pkg::RegFade:    fade_distance <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fcts_pkg::RegEye:     prdata = eye_height;
      fcts_pkg::RegHorizon: prdata = {21'd0, horizon_row};
      fcts_pkg::RegFade:    prdata = fade_distance;
      default:              prdata = 32'd0;
    endcase
  end

  // Global advance: the pipe moves whenever the output queue has room
  logic [1:0] q_count;
  logic       adv;
  assign adv      = (q_count != 2'd2);
  assign s_tready = adv;

  // Entry: unpack the request and prepare the signed division
  fcts_pkg::item_t in_item;
  fcts_pkg::geom_t in_geom;
  logic [12:0] off_s;
  logic [11:0] off_mag;
  logic [31:0] eye_mag;

  always_comb begin
    in_item.kind   = s_tuser;
    in_item.column = s_tdata[11:0];
    in_item.row    = s_tdata[23:12];
    in_item.last   = s_tlast;
    in_item.idx    = s_tdata[163:152];
    in_item.color  = s_tdata[187:164];
    in_geom.base_u = s_tdata[55:24];
    in_geom.base_v = s_tdata[87:56];
    in_geom.step_u = s_tdata[119:88];
    in_geom.step_v = s_tdata[151:120];
    if (s_tuser == fcts_pkg::KindCeil)
      off_s = {2'b00, horizon_row} - {1'b0, s_tdata[23:12]};
    else
      off_s = {1'b0, s_tdata[23:12]} - {2'b00, horizon_row};
    off_mag = off_s[12] ? 12'(-off_s) : off_s[11:0];
    eye_mag = eye_height[31] ? (32'd0 - eye_height) : eye_height;
  end

  // Distance divider: one quotient bit per stage, MSB first
  logic                a_valid [0:Nd];
  fcts_pkg::item_t     a_item  [0:Nd];
  fcts_pkg::geom_t     a_geom  [0:Nd];
  logic [31:0]         a_rem   [0:Nd];
  logic [31:0]         a_q     [0:Nd];
  logic [11:0]         a_den   [0:Nd];
  logic                a_neg   [0:Nd];
  logic                a_zero  [0:Nd];
  logic [31:0]         a_rem_next [0:Nd-1];
  logic [31:0]         a_q_next   [0:Nd-1];

  always_comb begin
    logic [43:0] trial;
    for (int k = 0; k < Nd; k++) begin
      trial = 44'(a_den[k]) << (Nd - 1 - k);
      if (44'(a_rem[k]) >= trial) begin
        a_rem_next[k] = a_rem[k] - trial[31:0];
        a_q_next[k]   = a_q[k] | (32'd1 << (Nd - 1 - k));
      end else begin
        a_rem_next[k] = a_rem[k];
        a_q_next[k]   = a_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Nd; k++) a_valid[k] <= 1'b0;
    end else if (adv) begin
      // drop unknown kinds at the door
      a_valid[0] <= s_tvalid && (s_tuser != fcts_pkg::KindNone);
      for (int k = 0; k < Nd; k++) a_valid[k+1] <= a_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item[0] <= in_item;
      a_geom[0] <= in_geom;
      a_rem[0]  <= eye_mag;
      a_q[0]    <= 32'd0;
      a_den[0]  <= off_mag;
      a_neg[0]  <= eye_height[31] ^ off_s[12];
      a_zero[0] <= (off_s == 13'd0);
      for (int k = 0; k < Nd; k++) begin
        a_item[k+1] <= a_item[k];
        a_geom[k+1] <= a_geom[k];
        a_rem[k+1]  <= a_rem_next[k];
        a_q[k+1]    <= a_q_next[k];
        a_den[k+1]  <= a_den[k];
        a_neg[k+1]  <= a_neg[k];
        a_zero[k+1] <= a_zero[k];
      end
    end
  end

  // Signed distance with saturation; the horizon row gives the maximum
  logic            b_valid;
  fcts_pkg::item_t b_item;
  fcts_pkg::geom_t b_geom;
  logic [31:0]     b_dist;
  logic [31:0]     b_mag;

  // Products: texture steps times distance, and distance squared
  logic            c_valid;
  fcts_pkg::item_t c_item;
  fcts_pkg::geom_t c_geom;
  logic [63:0]     c_pu;
  logic [63:0]     c_pv;
  logic [63:0]     c_pd;

  // Back to Q32.16 and form the shade denominator
  logic            e_valid;
  fcts_pkg::item_t e_item;
  fcts_pkg::geom_t e_geom;
  logic [47:0]     e_tu;
  logic [47:0]     e_tv;
  logic [47:0]     e_den;

  // Saturated texture coordinates
  logic            f_valid;
  fcts_pkg::item_t f_item;
  logic [31:0]     f_u;
  logic [31:0]     f_v;
  logic [47:0]     f_den;

  // Texel address
  logic                          g_valid;
  fcts_pkg::item_t               g_item;
  logic [fcts_pkg::StoreAw-1:0]  g_addr;
  logic [47:0]                   g_den;

  logic [48:0] f_su;
  logic [48:0] f_sv;
  logic [48:0] bu_ext;
  logic [48:0] bv_ext;
  logic [2*fcts_pkg::TexSideLog2-1:0] g_cat;

  always_comb begin
    bu_ext = {{17{e_geom.base_u[31]}}, e_geom.base_u};
    bv_ext = {{17{e_geom.base_v[31]}}, e_geom.base_v};
    f_su   = bu_ext + {e_tu[47], e_tu};
    // floor subtracts the v step, ceiling mirrors the origin
    if (e_item.kind == fcts_pkg::KindCeil) f_sv = {e_tv[47], e_tv} - bv_ext;
    else                                   f_sv = bv_ext - {e_tv[47], e_tv};
    g_cat = {fcts_pkg::coord_wrap(f_v), fcts_pkg::coord_wrap(f_u)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid[Nd];
      c_valid <= b_valid;
      e_valid <= c_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item <= a_item[Nd];
      b_geom <= a_geom[Nd];
      if (a_zero[Nd]) begin
        b_dist <= 32'h7FFF_FFFF;
        b_mag  <= 32'h7FFF_FFFF;
      end else if (a_neg[Nd]) begin
        b_dist <= 32'd0 - a_q[Nd];
        b_mag  <= a_q[Nd];
      end else if (a_q[Nd][31]) begin
        b_dist <= 32'h7FFF_FFFF;
        b_mag  <= 32'h7FFF_FFFF;
      end else begin
        b_dist <= a_q[Nd];
        b_mag  <= a_q[Nd];
      end

      c_item <= b_item;
      c_geom <= b_geom;
      c_pu   <= 64'($signed(b_geom.step_u) * $signed(b_dist));
      c_pv   <= 64'($signed(b_geom.step_v) * $signed(b_dist));
      c_pd   <= 64'(b_mag) * 64'(b_mag);

      e_item <= c_item;
      e_geom <= c_geom;
      e_tu   <= fcts_pkg::trunc16(c_pu);
      e_tv   <= fcts_pkg::trunc16(c_pv);
      e_den  <= 48'(fade_distance) + c_pd[63:16];

      f_item <= e_item;
      f_u    <= fcts_pkg::sat32(f_su);
      f_v    <= fcts_pkg::sat32(f_sv);
      f_den  <= e_den;

      g_item <= f_item;
      g_addr <= fcts_pkg::StoreAw'(g_cat);
      g_den  <= f_den;
    end
  end

  // Texture store: loads write and pixels read at the same stage, one port
  logic [23:0] tex_mem [0:fcts_pkg::StoreDepth-1];
  logic [23:0] tex_rd;

  always_ff @(posedge clk) begin
    if (adv && g_valid) begin
      if (g_item.kind == fcts_pkg::KindLoad) tex_mem[g_item.idx] <= g_item.color;
      else                                   tex_rd <= tex_mem[g_addr];
    end
  end

  // Shade divider: fade * 2^16 / den, one quotient bit per stage
  logic            s_valid [0:Ns];
  fcts_pkg::item_t s_item  [0:Ns];
  logic [47:0]     s_rem   [0:Ns];
  logic [47:0]     s_den   [0:Ns];
  logic [16:0]     s_q     [0:Ns];
  logic [23:0]     s_texel [1:Ns];
  logic [47:0]     s_rem_next [0:Ns-1];
  logic [16:0]     s_q_next   [0:Ns-1];

  always_comb begin
    logic [63:0] trial;
    for (int k = 0; k < Ns; k++) begin
      trial = 64'(s_den[k]) << (Ns - 1 - k);
      if (64'(s_rem[k]) >= trial) begin
        s_rem_next[k] = s_rem[k] - trial[47:0];
        s_q_next[k]   = s_q[k] | (17'd1 << (Ns - 1 - k));
      end else begin
        s_rem_next[k] = s_rem[k];
        s_q_next[k]   = s_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Ns; k++) s_valid[k] <= 1'b0;
    end else if (adv) begin
      // loads end at the store
      s_valid[0] <= g_valid && (g_item.kind != fcts_pkg::KindLoad);
      for (int k = 0; k < Ns; k++) s_valid[k+1] <= s_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_item[0]  <= g_item;
      s_rem[0]   <= {fade_distance, 16'd0};
      s_den[0]   <= g_den;
      s_q[0]     <= 17'd0;
      s_texel[1] <= tex_rd;
      for (int k = 0; k < Ns; k++) begin
        s_item[k+1] <= s_item[k];
        s_rem[k+1]  <= s_rem_next[k];
        s_den[k+1]  <= s_den[k];
        s_q[k+1]    <= s_q_next[k];
      end
      for (int k = 1; k < Ns; k++) s_texel[k+1] <= s_texel[k];
    end
  end

  // Scale each channel; a zero denominator gives black
  logic [16:0]    shade;
  logic [24:0]    prod_r;
  logic [24:0]    prod_g;
  logic [24:0]    prod_b;
  fcts_pkg::out_t res;

  always_comb begin
    shade  = (s_den[Ns] == 48'd0) ? 17'd0 : s_q[Ns];
    prod_r = 25'(s_texel[Ns][23:16]) * 25'(shade);
    prod_g = 25'(s_texel[Ns][15:8])  * 25'(shade);
    prod_b = 25'(s_texel[Ns][7:0])   * 25'(shade);
    res.last   = s_item[Ns].last;
    res.color  = {prod_r[23:16], prod_g[23:16], prod_b[23:16]};
    res.row    = s_item[Ns].row;
    res.column = s_item[Ns].column;
  end

  // Two-entry output queue
  fcts_pkg::out_t q_mem [0:1];
  logic           q_wr;
  logic           q_rd;
  logic           push;
  logic           pop;

  assign push     = adv && s_valid[Ns];
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (q_count != 2'd0);
  assign m_tdata  = {q_mem[q_rd].color, q_mem[q_rd].row, q_mem[q_rd].column};
  assign m_tlast  = q_mem[q_rd].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
      q_wr    <= 1'b0;
      q_rd    <= 1'b0;
    end else begin
      if (push) q_wr <= ~q_wr;
      if (pop)  q_rd <= ~q_rd;
      q_count <= q_count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[q_wr] <= res;
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the floor and ceiling texel shader.
module tb;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic         m_tlast;

  floor_ceiling_texel_shader u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the registers and the texture store.
  logic signed [31:0] eye_q;
  logic [10:0]        horizon_q;
  logic [31:0]        fade_q;
  logic [23:0]        texels [0:fcts_pkg::StoreDepth-1];
  logic               written [0:fcts_pkg::StoreDepth-1];

  typedef struct packed {
    logic        last;
    logic [23:0] color;
    logic [11:0] row;
    logic [11:0] column;
  } pixel_t;

  pixel_t pixels_due[$];
  int     fails = 0;
  int     quiet = 0;
  int     accepted = 0;
  bit     idle_on = 1'b1;
  bit     done = 1'b0;

  function automatic longint sat_s32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic int wrap_whole(input longint q);
    longint w, m;
    w = q / 65536;
    m = w % fcts_pkg::TexSide;
    if (m < 0) m += fcts_pkg::TexSide;
    return int'(m);
  endfunction

  // Work out the store address a pixel request reads, and its distance.
  function automatic void locate(input logic [1:0] kind, input logic [11:0] row,
                                 input logic [31:0] bu, bv, su, sv,
                                 output int addr, output longint dval);
    longint off, u, v;
    off = (kind == fcts_pkg::KindFloor) ? longint'(row) - longint'(horizon_q)
                                        : longint'(horizon_q) - longint'(row);
    if (off == 0) dval = 64'sd2147483647;
    else dval = sat_s32(longint'(eye_q) / off);
    u = sat_s32(longint'($signed(bu)) + (longint'($signed(su)) * dval) / 65536);
    if (kind == fcts_pkg::KindFloor)
      v = sat_s32(longint'($signed(bv)) - (longint'($signed(sv)) * dval) / 65536);
    else
      v = sat_s32(-longint'($signed(bv)) + (longint'($signed(sv)) * dval) / 65536);
    addr = (wrap_whole(v) * fcts_pkg::TexSide + wrap_whole(u)) % fcts_pkg::StoreDepth;
  endfunction

  function automatic pixel_t shade_pixel(input logic [1:0] kind, input logic [11:0] col,
                                         input logic [11:0] row, input logic last,
                                         input logic [31:0] bu, bv, su, sv);
    pixel_t p;
    int addr;
    longint dval;
    logic [63:0] mag, d2, den, sh;
    logic [23:0] tx;
    locate(kind, row, bu, bv, su, sv, addr, dval);
    tx = texels[addr];
    mag = (dval < 0) ? -dval : dval;
    d2 = (mag * mag) >> 16;
    den = {32'd0, fade_q} + d2;
    sh = (den == 0) ? 64'd0 : ({32'd0, fade_q} << 16) / den;
    p.column = col;
    p.row = row;
    p.last = last;
    p.color[23:16] = 8'(({56'd0, tx[23:16]} * sh) >> 16);
    p.color[15:8]  = 8'(({56'd0, tx[15:8]} * sh) >> 16);
    p.color[7:0]   = 8'(({56'd0, tx[7:0]} * sh) >> 16);
    return p;
  endfunction

  // Write one register over APB: setup, then access.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      fcts_pkg::RegEye:     eye_q = val;
      fcts_pkg::RegHorizon: horizon_q = val[10:0];
      fcts_pkg::RegFade:    fade_q = val;
      default: ;
    endcase
  endtask

  // Drain all expected pixels, then let the pipe empty of loads too.
  task automatic settle();
    while (pixels_due.size() != 0 && quiet < 4000) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Send one request; prediction happens at acceptance.
  task automatic send(input logic [1:0] kind, input logic [11:0] col, row,
                      input logic [31:0] bu, bv, su, sv,
                      input logic [11:0] idx, input logic [23:0] color,
                      input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tlast <= last;
    s_tdata <= {4'd0, color, idx, sv, su, bv, bu, row, col};
    do @(posedge clk); while (!s_tready);
    accepted++;
    if (kind == fcts_pkg::KindLoad) begin
      texels[idx] = color;
      written[idx] = 1'b1;
    end else if (kind == fcts_pkg::KindFloor || kind == fcts_pkg::KindCeil) begin
      pixels_due.push_back(shade_pixel(kind, col, row, last, bu, bv, su, sv));
    end
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task automatic load_texel(input int idx, input logic [23:0] color);
    send(fcts_pkg::KindLoad, 12'($urandom), 12'($urandom), $urandom, $urandom, $urandom,
         $urandom, 12'(idx), color, 1'($urandom));
  endtask

  // Pixel request, loading the texel it reads first if it has not been loaded.
  task automatic try_pixel(input logic [1:0] kind, input logic [11:0] col, row,
                           input logic [31:0] bu, bv, su, sv, input logic last);
    int addr;
    longint dval;
    locate(kind, row, bu, bv, su, sv, addr, dval);
    if (!written[addr]) load_texel(addr, 24'($urandom));
    send(kind, col, row, bu, bv, su, sv, 12'($urandom), 24'($urandom), last);
  endtask

  // Seed a few texels; pixel requests load whatever else they read.
  task automatic test_fill_store();
    for (int i = 0; i < 3; i++)
      load_texel(i, (i == 0) ? 24'hFFFFFF : (i == 1) ? 24'h000000 : 24'h808080);
    stop_sending();
  endtask

  task automatic test_directed();
    try_pixel(fcts_pkg::KindFloor, 12'd0, 12'd240, 0, 0, 0, 0, 1'b0);
    try_pixel(fcts_pkg::KindCeil, 12'hFFF, 12'd240, 0, 0, 0, 0, 1'b1);
    try_pixel(fcts_pkg::KindFloor, 12'd5, 12'hFFF, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 1'b1);
    try_pixel(fcts_pkg::KindCeil, 12'd7, 12'd0, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 1'b0);
    try_pixel(fcts_pkg::KindFloor, 12'd9, 12'd241, 32'hFFFF0000, 32'h00010000,
              32'hFFFFFFFF, 32'h00000001, 1'b0);
    try_pixel(fcts_pkg::KindCeil, 12'd3, 12'd239, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1'b1);
    send(fcts_pkg::KindNone, 12'd1, 12'd2, 0, 0, 0, 0, 12'hFFF, 24'hFFFFFF, 1'b1);
    load_texel(4095, 24'hFFFFFF);
    stop_sending();
    settle();
    // Zero fade and zero eye height, below the horizon: black pixel.
    write_reg(fcts_pkg::RegFade, 32'd0);
    write_reg(fcts_pkg::RegEye, 32'd0);
    try_pixel(fcts_pkg::KindFloor, 12'd1, 12'd300, 0, 0, 0, 0, 1'b1);
    stop_sending();
    settle();
    write_reg(fcts_pkg::RegHorizon, 32'd300);
    settle();
    try_pixel(fcts_pkg::KindFloor, 12'd1, 12'd300, 0, 0, 0, 0, 1'b1);
    try_pixel(fcts_pkg::KindCeil, 12'd1, 12'd300, 32'h12345678, 0, 0, 0, 1'b0);
    stop_sending();
    settle();
  endtask

  // Send n requests in all, counting the loads that pixel requests pull in.
  task automatic random_phase(input int n, input logic [31:0] eye, input logic [10:0] hz,
                              input logic [31:0] fade);
    logic [1:0] k;
    logic [11:0] r;
    int first;
    settle();
    write_reg(fcts_pkg::RegEye, eye);
    write_reg(fcts_pkg::RegHorizon, 32'(hz));
    write_reg(fcts_pkg::RegFade, fade);
    first = accepted;
    while (accepted - first < n) begin
      k = ($urandom_range(0, 9) == 0) ? fcts_pkg::KindLoad
                                      : ($urandom_range(0, 1) ? fcts_pkg::KindFloor
                                                              : fcts_pkg::KindCeil);
      r = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'(hz + $urandom_range(0, 60) - 30);
      if ($urandom_range(0, 30) == 0) k = fcts_pkg::KindNone;
      if (k == fcts_pkg::KindLoad)
        load_texel($urandom_range(0, fcts_pkg::StoreDepth - 1), 24'($urandom));
      else if (k == fcts_pkg::KindNone)
        send(k, 12'($urandom), r, $urandom, $urandom, $urandom, $urandom,
             12'($urandom), 24'($urandom), 1'($urandom));
      else
        try_pixel(k, 12'($urandom), r,
                  $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 22)),
                  $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 22)),
                  $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 1 << 18))
                                                        - (1 << 17)),
                  $urandom, 1'($urandom));
    end
    stop_sending();
  endtask

  // Receiver: random stall bursts, none in the final stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Check each accepted pixel against the oldest prediction.
  pixel_t got, want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata[47:24], m_tdata[23:12], m_tdata[11:0]};
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel %h", got);
        fails++;
      end else begin
        want = pixels_due.pop_front();
        if (got.column !== want.column) begin
          $error("out_column exp %h got %h", want.column, got.column); fails++;
        end
        if (got.row !== want.row) begin
          $error("out_row exp %h got %h", want.row, got.row); fails++;
        end
        if (got.color !== want.color) begin
          $error("pixel_color exp %h got %h", want.color, got.color); fails++;
        end
        if (got.last !== want.last) begin
          $error("out_last exp %b got %b", want.last, got.last); fails++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either stream and no APB select.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000 && !done) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    eye_q = 32'sd32768;
    horizon_q = 11'd240;
    fade_q = 32'd65536;
    for (int i = 0; i < fcts_pkg::StoreDepth; i++) written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_store();
    test_directed();
    random_phase(120, 32'sd32768, 11'd240, 32'd65536);
    random_phase(100, 32'h7FFFFFFF, 11'd0, 32'hFFFFFFFF);
    random_phase(100, 32'h80000000, 11'd2047, 32'd1);
    random_phase(100, $urandom, 11'($urandom), $urandom);
    idle_on = 1'b0;
    random_phase(120, 32'sd1 << 20, 11'd512, 32'd1 << 18);
    settle();
    done = 1'b1;
    if (fails == 0 && pixels_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
